### rtl/cpts_pkg.sv
// Shared constants, payload types and helpers for the two-set closest pair block.
`timescale 1ns / 1ps

package cpts_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int COORD_BITS  = 16;
    localparam int FIELD_BITS  = 16;
    localparam int DIST_W      = 34;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int SQ_W        = 2 * COORD_BITS;
    localparam int SUM_W       = SQ_W + 1;
    localparam int PT_W        = 2 * COORD_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [FIELD_BITS-1:0] field_t;

    typedef struct packed {
        logic   kind;
        field_t point_x;
        field_t point_y;
        logic   last;
    } item_t;

    typedef struct packed {
        field_t              first_x;
        field_t              first_y;
        field_t              second_x;
        field_t              second_y;
        logic [DIST_W-1:0]   dist_sq;
        logic                found;
        logic                overflow;
    } result_t;

    typedef enum logic {
        SET_FIRST  = 1'b0,
        SET_SECOND = 1'b1
    } set_sel_t;

    typedef struct packed {
        set_sel_t set_sel;
        logic     search;
        coord_t   x;
        coord_t   y;
    } cmd_t;

    function automatic coord_t to_coord(input field_t raw);
        return coord_t'(raw);
    endfunction

    function automatic field_t from_coord(input coord_t c);
        return field_t'(c);
    endfunction

    function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] s);
        if (SUM_W > DIST_W && (s >> DIST_W) != '0)
        begin
            return '1;
        end
        return DIST_W'(s);
    endfunction

endpackage

### rtl/cpts_if.sv
// Valid/ready channel interfaces for point items and search results.
`timescale 1ns / 1ps

interface cpts_in_if;
    logic             valid;
    logic             ready;
    cpts_pkg::item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpts_out_if;
    logic              valid;
    logic              ready;
    cpts_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/closest_pair_two_point_sets_top.sv
// Top level of the two-set closest pair search: front end, command queue, search engine.
//
//   channel   dir   fields                                            transfer
//   in_ch     in    kind, point_x, point_y, last                      valid && ready
//   out_ch    out   first_x/y, second_x/y, dist_sq, found, overflow   valid && ready
//
// Point items load at one per cycle, while no search runs, into two 1024-entry stores.
// An item with last set runs the search: one pair per cycle through the store read ports,
// then through pipeline stages s2 and s3 to the best-pair registers and the result.
// Input stalls once the four-entry queue and the front-end register fill behind a running search.
// No clearing pass after reset; only store entries below the fill counts are read.
// A result waits in the output register; the next result holds until it is taken.
`timescale 1ns / 1ps

module closest_pair_two_point_sets_top (
    input  logic        clk,
    input  logic        rst_n,
    cpts_in_if.sink     in_ch,
    cpts_out_if.source  out_ch
);

    logic           front_valid;
    logic           front_ready;
    cpts_pkg::cmd_t front_cmd;
    logic           queue_valid;
    logic           queue_ready;
    cpts_pkg::cmd_t queue_cmd;

    cpts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    cpts_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    cpts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (queue_valid),
        .pop_ready (queue_ready),
        .pop_cmd   (queue_cmd),
        .out_ch    (out_ch)
    );

endmodule

### rtl/cpts_front.sv
// Front end: accept point items, wrap coordinates and classify them into commands.
`timescale 1ns / 1ps

module cpts_front (
    input  logic           clk,
    input  logic           rst_n,
    cpts_in_if.sink        in_ch,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output cpts_pkg::cmd_t cmd
);

    logic           valid_reg;
    logic           valid_next;
    cpts_pkg::cmd_t cmd_reg;
    cpts_pkg::cmd_t cmd_next;
    logic           take;

    assign in_ch.ready = !valid_reg || cmd_ready;
    assign take        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = valid_reg;
    assign cmd         = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (valid_reg && cmd_ready)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next       = 1'b1;
            cmd_next.set_sel = in_ch.data.kind ? cpts_pkg::SET_SECOND : cpts_pkg::SET_FIRST;
            cmd_next.search  = in_ch.data.last;
            cmd_next.x       = cpts_pkg::to_coord(in_ch.data.point_x);
            cmd_next.y       = cpts_pkg::to_coord(in_ch.data.point_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

### rtl/cpts_fifo.sv
// Short command queue between the front end and the search engine.
`timescale 1ns / 1ps

module cpts_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  cpts_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output cpts_pkg::cmd_t pop_data
);

    cpts_pkg::cmd_t                      slots [cpts_pkg::QUEUE_DEPTH];
    logic [cpts_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [cpts_pkg::QPTR_W-1:0]         wr_ptr_next;
    logic [cpts_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [cpts_pkg::QPTR_W-1:0]         rd_ptr_next;
    logic [cpts_pkg::QCNT_W-1:0]         count_reg;
    logic [cpts_pkg::QCNT_W-1:0]         count_next;
    logic                                do_push;
    logic                                do_pop;

    assign push_ready = count_reg != cpts_pkg::QCNT_W'(cpts_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + cpts_pkg::QCNT_W'(do_push) - cpts_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/cpts_back.sv
// Back end: point stores, pipelined pair search and result register.
`timescale 1ns / 1ps

module cpts_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  cpts_pkg::cmd_t pop_cmd,
    cpts_out_if.source     out_ch
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    localparam int C = cpts_pkg::COORD_BITS;

    state_t                         state_reg, state_next;
    logic [cpts_pkg::CNT_W-1:0]     cnt_a_reg, cnt_a_next;
    logic [cpts_pkg::CNT_W-1:0]     cnt_b_reg, cnt_b_next;
    logic                           ovf_reg, ovf_next;
    logic                           found_reg, found_next;
    logic [cpts_pkg::ADDR_W-1:0]    idx_i_reg, idx_i_next;
    logic [cpts_pkg::ADDR_W-1:0]    idx_j_reg, idx_j_next;
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_first_reg, s1_first_next;
    logic                           s2_valid_reg, s3_valid_reg;
    logic                           s2_first_reg, s3_first_reg;
    logic [cpts_pkg::DIST_W-1:0]    best_dist_reg, best_dist_next;
    logic                           out_valid_reg, out_valid_next;
    cpts_pkg::result_t              out_data_reg, out_data_next;

    logic [cpts_pkg::PT_W-1:0]      mem_a [cpts_pkg::MAX_POINTS];
    logic [cpts_pkg::PT_W-1:0]      mem_b [cpts_pkg::MAX_POINTS];
    logic [cpts_pkg::PT_W-1:0]      rd_a_reg, rd_b_reg;

    logic                           wr_a_en, wr_b_en;
    logic                           take;
    logic                           full_a, full_b;
    logic                           last_i, last_j;

    cpts_pkg::coord_t               ax, ay, bx, by;
    logic signed [cpts_pkg::DIFF_W-1:0] dx, dy;
    logic [C-1:0]                   ux, uy;
    logic [C-1:0]                   s2_ux_reg, s2_uy_reg;
    cpts_pkg::coord_t               s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg;
    logic [cpts_pkg::SQ_W-1:0]      s3_sqx_reg, s3_sqy_reg;
    cpts_pkg::coord_t               s3_ax_reg, s3_ay_reg, s3_bx_reg, s3_by_reg;
    cpts_pkg::coord_t               best_ax_reg, best_ay_reg, best_bx_reg, best_by_reg;
    logic [cpts_pkg::SUM_W-1:0]     sum;
    logic [cpts_pkg::DIST_W-1:0]    pair_dist;
    logic                           better;

    assign pop_ready    = state_reg == ST_LOAD;
    assign take         = pop_valid && pop_ready;
    assign full_a       = cnt_a_reg == cpts_pkg::CNT_W'(cpts_pkg::MAX_POINTS);
    assign full_b       = cnt_b_reg == cpts_pkg::CNT_W'(cpts_pkg::MAX_POINTS);
    assign wr_a_en      = take && pop_cmd.set_sel == cpts_pkg::SET_FIRST && !full_a;
    assign wr_b_en      = take && pop_cmd.set_sel == cpts_pkg::SET_SECOND && !full_b;
    assign last_i       = cpts_pkg::CNT_W'(idx_i_reg) == cnt_a_reg - cpts_pkg::CNT_W'(1);
    assign last_j       = cpts_pkg::CNT_W'(idx_j_reg) == cnt_b_reg - cpts_pkg::CNT_W'(1);

    assign ax = rd_a_reg[2*C-1:C];
    assign ay = rd_a_reg[C-1:0];
    assign bx = rd_b_reg[2*C-1:C];
    assign by = rd_b_reg[C-1:0];

    always_comb
    begin
        dx = cpts_pkg::DIFF_W'(ax) - cpts_pkg::DIFF_W'(bx);
        dy = cpts_pkg::DIFF_W'(ay) - cpts_pkg::DIFF_W'(by);
        ux = dx[cpts_pkg::DIFF_W-1] ? C'(-dx) : C'(dx);
        uy = dy[cpts_pkg::DIFF_W-1] ? C'(-dy) : C'(dy);
    end

    always_comb
    begin
        sum       = cpts_pkg::SUM_W'(s3_sqx_reg) + cpts_pkg::SUM_W'(s3_sqy_reg);
        pair_dist = cpts_pkg::sat_dist(sum);
        better    = s3_valid_reg && (s3_first_reg || pair_dist < best_dist_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ovf_next       = ovf_reg;
        found_next     = found_reg;
        idx_i_next     = idx_i_reg;
        idx_j_next     = idx_j_reg;
        s1_valid_next  = 1'b0;
        s1_first_next  = 1'b0;
        best_dist_next = better ? pair_dist : best_dist_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (take)
                begin
                    if (pop_cmd.set_sel == cpts_pkg::SET_FIRST)
                    begin
                        if (full_a)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            cnt_a_next = cnt_a_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (full_b)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            cnt_b_next = cnt_b_reg + 1'b1;
                        end
                    end
                    if (pop_cmd.search)
                    begin
                        found_next = cnt_a_next != '0 && cnt_b_next != '0;
                        idx_i_next = '0;
                        idx_j_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!found_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    s1_valid_next = 1'b1;
                    s1_first_next = idx_i_reg == '0 && idx_j_reg == '0;
                    if (last_j)
                    begin
                        idx_j_next = '0;
                        idx_i_next = idx_i_reg + 1'b1;
                        if (last_i)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    else
                    begin
                        idx_j_next = idx_j_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.found    = found_reg;
                    out_data_next.overflow = ovf_reg;
                    if (found_reg)
                    begin
                        out_data_next.first_x  = cpts_pkg::from_coord(best_ax_reg);
                        out_data_next.first_y  = cpts_pkg::from_coord(best_ay_reg);
                        out_data_next.second_x = cpts_pkg::from_coord(best_bx_reg);
                        out_data_next.second_y = cpts_pkg::from_coord(best_by_reg);
                        out_data_next.dist_sq  = best_dist_reg;
                    end
                    else
                    begin
                        out_data_next.first_x  = '0;
                        out_data_next.first_y  = '0;
                        out_data_next.second_x = '0;
                        out_data_next.second_y = '0;
                        out_data_next.dist_sq  = '0;
                    end
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            found_reg     <= 1'b0;
            idx_i_reg     <= '0;
            idx_j_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_first_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s3_first_reg  <= 1'b0;
            best_dist_reg <= '1;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ovf_reg       <= ovf_next;
            found_reg     <= found_next;
            idx_i_reg     <= idx_i_next;
            idx_j_reg     <= idx_j_next;
            s1_valid_reg  <= s1_valid_next;
            s1_first_reg  <= s1_first_next;
            s2_valid_reg  <= s1_valid_reg;
            s2_first_reg  <= s1_first_reg;
            s3_valid_reg  <= s2_valid_reg;
            s3_first_reg  <= s2_first_reg;
            best_dist_reg <= best_dist_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            mem_a[cnt_a_reg[cpts_pkg::ADDR_W-1:0]] <= {pop_cmd.x, pop_cmd.y};
        end
        if (wr_b_en)
        begin
            mem_b[cnt_b_reg[cpts_pkg::ADDR_W-1:0]] <= {pop_cmd.x, pop_cmd.y};
        end
        rd_a_reg <= mem_a[idx_i_reg];
        rd_b_reg <= mem_b[idx_j_reg];
    end

    always_ff @(posedge clk)
    begin
        s2_ux_reg  <= ux;
        s2_uy_reg  <= uy;
        s2_ax_reg  <= ax;
        s2_ay_reg  <= ay;
        s2_bx_reg  <= bx;
        s2_by_reg  <= by;
        s3_sqx_reg <= cpts_pkg::SQ_W'(s2_ux_reg) * cpts_pkg::SQ_W'(s2_ux_reg);
        s3_sqy_reg <= cpts_pkg::SQ_W'(s2_uy_reg) * cpts_pkg::SQ_W'(s2_uy_reg);
        s3_ax_reg  <= s2_ax_reg;
        s3_ay_reg  <= s2_ay_reg;
        s3_bx_reg  <= s2_bx_reg;
        s3_by_reg  <= s2_by_reg;
        if (better)
        begin
            best_ax_reg <= s3_ax_reg;
            best_ay_reg <= s3_ay_reg;
            best_bx_reg <= s3_bx_reg;
            best_by_reg <= s3_by_reg;
        end
    end

endmodule

### rtl/cpts_checker.sv
// Port-level assertions for the closest pair block and their bind to the top level.
`timescale 1ns / 1ps

module cpts_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input cpts_pkg::result_t out_data
);

    logic signed [cpts_pkg::FIELD_BITS:0] dx, dy;
    logic [cpts_pkg::FIELD_BITS-1:0]      ux, uy;
    logic [cpts_pkg::DIST_W-1:0]          expect_dist;

    always_comb
    begin
        dx = (cpts_pkg::FIELD_BITS + 1)'(out_data.first_x)
           - (cpts_pkg::FIELD_BITS + 1)'(out_data.second_x);
        dy = (cpts_pkg::FIELD_BITS + 1)'(out_data.first_y)
           - (cpts_pkg::FIELD_BITS + 1)'(out_data.second_y);
        ux = dx[cpts_pkg::FIELD_BITS] ? cpts_pkg::FIELD_BITS'(-dx) : cpts_pkg::FIELD_BITS'(dx);
        uy = dy[cpts_pkg::FIELD_BITS] ? cpts_pkg::FIELD_BITS'(-dy) : cpts_pkg::FIELD_BITS'(dy);
        expect_dist = cpts_pkg::DIST_W'(ux) * cpts_pkg::DIST_W'(ux)
                    + cpts_pkg::DIST_W'(uy) * cpts_pkg::DIST_W'(uy);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |->
            out_data.dist_sq == '0 && out_data.first_x == '0 && out_data.first_y == '0
            && out_data.second_x == '0 && out_data.second_y == '0)
        else $error("empty search returned nonzero fields");

    a_dist_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> out_data.dist_sq == expect_dist)
        else $error("distance does not match the reported pair");

endmodule

bind closest_pair_two_point_sets_top cpts_checker u_cpts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

### tb/tb_top.sv
// Self-checking bench for the two-set closest pair search: random point jobs, stalls, result scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam longint DIST_SAT    = (longint'(1) << cpts_pkg::DIST_W) - 1;
    localparam int     SMALL_ITEMS = 900;

    logic clk;
    logic rst_n;

    cpts_in_if  in_ch();
    cpts_out_if out_ch();

    closest_pair_two_point_sets_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    cpts_pkg::item_t   point_q[$];
    cpts_pkg::result_t closest_q[$];
    cpts_pkg::result_t want;

    int items_total  = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int fail_count   = 0;

    longint set_a_x[cpts_pkg::MAX_POINTS];
    longint set_a_y[cpts_pkg::MAX_POINTS];
    longint set_b_x[cpts_pkg::MAX_POINTS];
    longint set_b_y[cpts_pkg::MAX_POINTS];
    int     count_a = 0;
    int     count_b = 0;
    bit     dropped = 1'b0;
    longint best_d  = DIST_SAT;
    int     best_i  = 0;
    int     best_j  = 0;

    int          burst_left;
    int          gap_left;
    int          hold_left;
    int          holds_done;
    logic [15:0] stall_pat;
    logic [8:0]  stall_phase;

    function automatic longint wrap_coord(input cpts_pkg::field_t raw);
        longint span;
        longint v;
        span = longint'(1) << cpts_pkg::COORD_BITS;
        v = longint'(raw) & (span - 1);
        if (v >= span / 2)
        begin
            v = v - span;
        end
        return v;
    endfunction

    function automatic cpts_pkg::field_t pick_coord(input int mode,
                                                    input cpts_pkg::field_t center);
        int m;
        m = (mode == 3) ? $urandom_range(0, 2) : mode;
        if (m == 0)
        begin
            return cpts_pkg::field_t'($urandom);
        end
        if (m == 1)
        begin
            return center + cpts_pkg::field_t'($urandom_range(0, 3));
        end
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic add_point(input cpts_pkg::set_sel_t kind, input cpts_pkg::field_t x,
                             input cpts_pkg::field_t y, input logic is_last);
        cpts_pkg::item_t it;
        it.kind    = kind;
        it.point_x = x;
        it.point_y = y;
        it.last    = is_last;
        point_q.insert(point_q.size(), it);
        items_total++;
    endtask

    task automatic queue_job(input int na, input int nb);
        cpts_pkg::set_sel_t kinds[$];
        cpts_pkg::set_sel_t sw;
        int                 mode;
        int                 order;
        int                 k;
        int                 pick;
        cpts_pkg::field_t   cx;
        cpts_pkg::field_t   cy;
        mode  = $urandom_range(0, 3);
        order = $urandom_range(0, 7);
        cx    = cpts_pkg::field_t'($urandom);
        cy    = cpts_pkg::field_t'($urandom);
        repeat (na) kinds.insert(kinds.size(), cpts_pkg::SET_FIRST);
        repeat (nb) kinds.insert(kinds.size(), cpts_pkg::SET_SECOND);
        if (order == 6)
        begin
            for (k = kinds.size() - 1; k > 0; k--)
            begin
                pick        = $urandom_range(0, k);
                sw          = kinds[k];
                kinds[k]    = kinds[pick];
                kinds[pick] = sw;
            end
        end
        else if (order == 7 && na > 0)
        begin
            // move one first-set point to the end so it carries last
            void'(kinds.pop_front());
            kinds.insert(kinds.size(), cpts_pkg::SET_FIRST);
        end
        for (k = 0; k < kinds.size(); k++)
        begin
            add_point(kinds[k], pick_coord(mode, cx), pick_coord(mode, cy),
                      k == kinds.size() - 1);
        end
    endtask

    task automatic absorb_point(input cpts_pkg::item_t it);
        longint            px;
        longint            py;
        longint            dx;
        longint            dy;
        longint            d;
        cpts_pkg::result_t r;
        int                i;
        int                j;
        px = wrap_coord(it.point_x);
        py = wrap_coord(it.point_y);
        if (cpts_pkg::set_sel_t'(it.kind) == cpts_pkg::SET_FIRST)
        begin
            if (count_a < cpts_pkg::MAX_POINTS)
            begin
                set_a_x[count_a] = px;
                set_a_y[count_a] = py;
                count_a++;
            end
            else
            begin
                dropped = 1'b1;
            end
        end
        else
        begin
            if (count_b < cpts_pkg::MAX_POINTS)
            begin
                set_b_x[count_b] = px;
                set_b_y[count_b] = py;
                count_b++;
            end
            else
            begin
                dropped = 1'b1;
            end
        end
        if (!it.last)
        begin
            return;
        end
        for (i = 0; i < count_a; i++)
        begin
            for (j = 0; j < count_b; j++)
            begin
                dx = set_a_x[i] - set_b_x[j];
                dy = set_a_y[i] - set_b_y[j];
                d  = dx * dx + dy * dy;
                if (d > DIST_SAT)
                begin
                    d = DIST_SAT;
                end
                if ((i == 0 && j == 0) || d < best_d)
                begin
                    best_d = d;
                    best_i = i;
                    best_j = j;
                end
            end
        end
        r = '0;
        if (count_a > 0 && count_b > 0)
        begin
            r.first_x  = cpts_pkg::field_t'(set_a_x[best_i]);
            r.first_y  = cpts_pkg::field_t'(set_a_y[best_i]);
            r.second_x = cpts_pkg::field_t'(set_b_x[best_j]);
            r.second_y = cpts_pkg::field_t'(set_b_y[best_j]);
            r.dist_sq  = cpts_pkg::DIST_W'(best_d);
            r.found    = 1'b1;
        end
        r.overflow = dropped;
        closest_q.insert(closest_q.size(), r);
        count_a = 0;
        count_b = 0;
        dropped = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always #1 clk = ~clk;

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // driver: bursts with gaps, hold data until transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end
            else if (point_q.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= point_q.pop_front();
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left <= $urandom_range(50, 300);
                        gap_left   <= 0;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= $urandom_range(1, 6);
                    end
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_pat    <= '1;
            stall_phase  <= '0;
            hold_left    <= 0;
            holds_done   <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if ((holds_done == 0 && results_seen >= 5) ||
                 (holds_done == 1 && results_seen >= 60))
        begin
            holds_done   <= holds_done + 1;
            hold_left    <= 600;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            stall_phase  <= stall_phase + 1'b1;
            out_ch.ready <= stall_pat[0];
            if (stall_phase == '1)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pat <= '1;
                    1:       stall_pat <= 16'($urandom);
                    2:       stall_pat <= 16'hFEFE;
                    default: stall_pat <= 16'h00FF;
                endcase
            end
            else
            begin
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            absorb_point(in_ch.data);
            items_taken <= items_taken + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen <= results_seen + 1;
            if (closest_q.size() == 0)
            begin
                $error("result transfer with no search pending");
                fail_count++;
            end
            else
            begin
                want = closest_q.pop_front();
                check_field("first_x", want.first_x, out_ch.data.first_x);
                check_field("first_y", want.first_y, out_ch.data.first_y);
                check_field("second_x", want.second_x, out_ch.data.second_x);
                check_field("second_y", want.second_y, out_ch.data.second_y);
                check_field("dist_sq", want.dist_sq, out_ch.data.dist_sq);
                check_field("found", want.found, out_ch.data.found);
                check_field("overflow", want.overflow, out_ch.data.overflow);
            end
        end
    end

    initial
    begin
        int small_items;
        int na;
        int nb;
        int sz;
        bit ovf_done;

        add_point(cpts_pkg::SET_SECOND, 16'h0000, 16'h0000, 1'b1);
        add_point(cpts_pkg::SET_FIRST, 16'h0001, 16'h0002, 1'b1);
        add_point(cpts_pkg::SET_FIRST, 16'h8000, 16'h8000, 1'b0);
        add_point(cpts_pkg::SET_SECOND, 16'h7FFF, 16'h7FFF, 1'b1);
        add_point(cpts_pkg::SET_FIRST, 16'h7FFF, 16'h8000, 1'b0);
        add_point(cpts_pkg::SET_FIRST, 16'h8000, 16'h7FFF, 1'b0);
        add_point(cpts_pkg::SET_SECOND, 16'h8000, 16'h8000, 1'b0);
        add_point(cpts_pkg::SET_SECOND, 16'h7FFF, 16'h7FFF, 1'b1);
        add_point(cpts_pkg::SET_FIRST, 16'sd0, 16'sd0, 1'b0);
        add_point(cpts_pkg::SET_SECOND, 16'sd3, 16'sd4, 1'b0);
        add_point(cpts_pkg::SET_SECOND, -16'sd3, -16'sd4, 1'b0);
        add_point(cpts_pkg::SET_SECOND, 16'sd4, 16'sd3, 1'b0);
        add_point(cpts_pkg::SET_SECOND, -16'sd4, 16'sd3, 1'b1);
        add_point(cpts_pkg::SET_SECOND, 16'sd10, -16'sd10, 1'b0);
        add_point(cpts_pkg::SET_FIRST, -16'sd1, 16'sd1, 1'b0);
        add_point(cpts_pkg::SET_FIRST, 16'sd7, -16'sd7, 1'b1);
        add_point(cpts_pkg::SET_FIRST, 16'sd100, 16'sd200, 1'b0);
        add_point(cpts_pkg::SET_SECOND, 16'sd100, 16'sd200, 1'b1);
        add_point(cpts_pkg::SET_FIRST, 16'h5555, 16'hAAAA, 1'b0);
        add_point(cpts_pkg::SET_SECOND, 16'hAAAA, 16'h5555, 1'b1);

        small_items = 0;
        ovf_done    = 1'b0;
        while (small_items < SMALL_ITEMS)
        begin
            if (!ovf_done && small_items >= 450)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    queue_job(cpts_pkg::MAX_POINTS + $urandom_range(0, 2),
                              $urandom_range(1, 2));
                end
                else
                begin
                    queue_job($urandom_range(1, 2),
                              cpts_pkg::MAX_POINTS + $urandom_range(1, 2));
                end
                ovf_done = 1'b1;
            end
            na = $urandom_range(1, 10);
            nb = $urandom_range(1, 10);
            sz = $urandom_range(0, 19);
            if (sz == 0)
            begin
                na = 0;
            end
            else if (sz == 1)
            begin
                nb = 0;
            end
            else if (sz == 2)
            begin
                na = $urandom_range(20, 40);
                nb = $urandom_range(20, 40);
            end
            queue_job(na, nb);
            small_items += na + nb;
        end

        @(posedge rst_n);
        while (items_taken != items_total || closest_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (50) @(negedge clk);
        if (fail_count == 0 && closest_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
